>>> rtl/mur_pkg.sv
// Shared types and constants for the mini UART register block.
package mur_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_TX_TAKE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_IRQ     = 4'd0,
    REG_ENABLES = 4'd1,
    REG_IO      = 4'd2,
    REG_IER     = 4'd3,
    REG_IIR     = 4'd4,
    REG_LCR     = 4'd5,
    REG_MCR     = 4'd6,
    REG_LSR     = 4'd7,
    REG_MSR     = 4'd8,
    REG_SCRATCH = 4'd9,
    REG_CNTL    = 4'd10,
    REG_STAT    = 4'd11,
    REG_BAUD    = 4'd12
  } reg_idx_t;

  localparam int unsigned DLAB_BIT      = 7;
  localparam logic [7:0]  IIR_FIFO_BITS = 8'hC0;
  localparam logic [7:0]  MSR_VALUE     = 8'h10;
  localparam logic [7:0]  CNTL_RESET    = 8'h03;
  localparam logic [3:0]  LEVEL_CAP     = 4'd8;
  localparam logic [2:0]  IIR_ID_TX     = 3'b010;
  localparam logic [2:0]  IIR_ID_RX     = 3'b100;
  localparam logic [2:0]  IIR_ID_NONE   = 3'b001;

  typedef struct packed {
    op_t         op;
    logic [3:0]  reg_index;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_out;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [3:0] level;
  } fifo_stat_t;

endpackage

>>> rtl/mur_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface mur_in_if;
  import mur_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mur_out_if;
  import mur_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/mur_fifo.sv
// Byte FIFO with head-of-queue read data registered from its memory.
module mur_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mur_pkg::fifo_ctrl_t ctrl,
  input  logic [7:0]          push_data,
  output logic [7:0]          head_data,
  output mur_pkg::fifo_stat_t stat
);
  import mur_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > 4) ? CW : 4;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt, head_inc, wr_addr;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    rd_r;
  logic [AW:0]   tail_sum;

  // Tail slot is head plus count, wrapped once.
  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r);
  assign wr_addr  = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (ctrl.pop) begin
        head_nxt = head_inc;
      end
      if (ctrl.push && !ctrl.pop) begin
        count_nxt = count_r + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_addr] <= push_data;
    end
  end

  // Look ahead to the next head; forward a byte written into that slot.
  always_ff @(posedge clk) begin
    if (ctrl.push && (wr_addr == head_nxt)) begin
      rd_r <= push_data;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign head_data  = rd_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.level = (LW'(count_r) >= LW'(LEVEL_CAP)) ? LEVEL_CAP : 4'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count exceeds depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !stat.full)
    else $error("push into full fifo");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.empty)
    else $error("pop from empty fifo");
`endif

endmodule

>>> rtl/mini_uart_registers_core.sv
// Top level: mini UART register block with receive and transmit FIFOs.
//
//  channel   direction  payload                                  handshake
//  in_chan   sink       op, reg_index, write_data, rx_byte       valid/ready
//  out_chan  source     read_data, tx_valid, tx_byte, irq_out    valid/ready
//
// One transaction in gives exactly one result transaction out.
// Throughput is one transaction per cycle while out_chan is not stalled: a
// transaction sits in the input register, where the register file and both
// FIFOs update, and its result lands in the output register.
// The FIFO head byte comes from a registered read of its memory, fetched the
// cycle before it is needed.
// rst_n is synchronous, active low; it clears control state and FIFO pointers.
// A stall on out_chan holds the input register, which then drops in_chan.ready.
module mini_uart_registers_core #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input logic        clk,
  input logic        rst_n,
  mur_in_if.sink     in_chan,
  mur_out_if.source  out_chan
);
  import mur_pkg::*;

  // Input register stage
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      advance;

  // Output register
  logic      out_valid_r;
  out_item_t out_r, result;

  // Register file
  logic [7:0]  enables_r,   enables_nxt;
  logic [7:0]  ier_r,       ier_nxt;
  logic [7:0]  lcr_r,       lcr_nxt;
  logic [7:0]  mcr_r,       mcr_nxt;
  logic [7:0]  scratch_r,   scratch_nxt;
  logic [7:0]  cntl_r,      cntl_nxt;
  logic [15:0] baud_r,      baud_nxt;
  logic        overrun_r,   overrun_nxt;

  // FIFO hookup
  fifo_ctrl_t rx_ctrl, tx_ctrl, rx_ctrl_g, tx_ctrl_g;
  fifo_stat_t rx_stat, tx_stat;
  logic [7:0] rx_head, tx_head;

  logic       uart_on, dlab, reg_open;
  logic [3:0] idx;
  logic [7:0] lo;
  logic       tx_pend, rx_pend, irq_now;
  logic       rx_empty_nxt, tx_empty_nxt;
  logic [2:0] iir_id;

  // Advance the input register when the output register is free or draining.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item_r <= in_chan.payload;
    end
  end

  assign uart_on  = enables_r[0];
  assign dlab     = lcr_r[DLAB_BIT];
  assign idx      = s1_item_r.reg_index;
  assign lo       = s1_item_r.write_data[7:0];
  // IRQ and ENABLES stay reachable with the UART off; every other register access is gated.
  assign reg_open = uart_on || (idx == REG_IRQ) || (idx == REG_ENABLES);

  assign tx_pend = ier_r[1] && tx_stat.empty;
  assign rx_pend = ier_r[0] && !rx_stat.empty;
  assign irq_now = uart_on && (tx_pend || rx_pend);
  // Transmit wins over receive in the IIR.
  assign iir_id  = tx_pend ? IIR_ID_TX : (rx_pend ? IIR_ID_RX : IIR_ID_NONE);

  always_comb begin
    enables_nxt = enables_r;
    ier_nxt     = ier_r;
    lcr_nxt     = lcr_r;
    mcr_nxt     = mcr_r;
    scratch_nxt = scratch_r;
    cntl_nxt    = cntl_r;
    baud_nxt    = baud_r;
    overrun_nxt = overrun_r;
    rx_ctrl     = '0;
    tx_ctrl     = '0;
    result      = '0;
    case (s1_item_r.op)
      OP_READ: begin
        if (reg_open) begin
          case (reg_idx_t'(idx))
            REG_IRQ:     result.read_data = {31'b0, irq_now};
            REG_ENABLES: result.read_data = {24'b0, enables_r};
            REG_IO: begin
              if (dlab) begin
                lcr_nxt[DLAB_BIT] = 1'b0;
                result.read_data  = {24'b0, baud_r[7:0]};
              end else if (!rx_stat.empty) begin
                rx_ctrl.pop      = 1'b1;
                result.read_data = {24'b0, rx_head};
              end
            end
            REG_IER: begin
              result.read_data = dlab ? {24'b0, baud_r[15:8]} : {24'b0, ier_r};
            end
            // The interrupt id codes already sit in bits 2:0, no-pending flag included.
            REG_IIR:     result.read_data = {24'b0, IIR_FIFO_BITS | {5'b0, iir_id}};
            REG_LCR:     result.read_data = {24'b0, lcr_r};
            REG_MCR:     result.read_data = {24'b0, mcr_r};
            REG_LSR: begin
              result.read_data = {25'b0, tx_stat.empty, !tx_stat.full, 3'b0,
                                  overrun_r, !rx_stat.empty};
              overrun_nxt = 1'b0;
            end
            REG_MSR:     result.read_data = {24'b0, MSR_VALUE};
            REG_SCRATCH: result.read_data = {24'b0, scratch_r};
            REG_CNTL:    result.read_data = {24'b0, cntl_r};
            REG_STAT: begin
              result.read_data = {4'b0, tx_stat.level, 4'b0, rx_stat.level, 6'b0,
                                  rx_stat.empty && tx_stat.empty, tx_stat.empty,
                                  2'b0, tx_stat.full, overrun_r, tx_stat.empty,
                                  rx_stat.empty, !tx_stat.full, !rx_stat.empty};
            end
            REG_BAUD:    result.read_data = {16'b0, baud_r};
            default:     result.read_data = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (reg_open) begin
          case (reg_idx_t'(idx))
            REG_ENABLES: enables_nxt = lo;
            REG_IO: begin
              if (dlab) begin
                lcr_nxt[DLAB_BIT] = 1'b0;
                baud_nxt[7:0]     = lo;
              end else if (!tx_stat.full) begin
                tx_ctrl.push = 1'b1;
              end
            end
            REG_IER: begin
              if (dlab) begin
                baud_nxt[15:8] = lo;
              end else begin
                ier_nxt = lo;
              end
            end
            REG_IIR: begin
              rx_ctrl.clear = lo[1];
              tx_ctrl.clear = lo[2];
            end
            REG_LCR:     lcr_nxt     = lo;
            REG_MCR:     mcr_nxt     = lo;
            REG_SCRATCH: scratch_nxt = lo;
            REG_CNTL:    cntl_nxt    = lo;
            REG_BAUD:    baud_nxt    = s1_item_r.write_data;
            default:     ;
          endcase
        end
      end
      OP_RX_BYTE: begin
        // Line bytes land regardless of the enable bit; a full FIFO drops them.
        if (rx_stat.full) begin
          overrun_nxt = 1'b1;
        end else begin
          rx_ctrl.push = 1'b1;
        end
      end
      OP_TX_TAKE: begin
        if (!tx_stat.empty) begin
          tx_ctrl.pop     = 1'b1;
          result.tx_valid = 1'b1;
          result.tx_byte  = tx_head;
        end
      end
      default: ;
    endcase

    // Interrupt state as it stands after this transaction.
    rx_empty_nxt = rx_ctrl.clear || (!rx_ctrl.push &&
                   (rx_stat.empty || (rx_ctrl.pop && rx_stat.level == 4'd1)));
    tx_empty_nxt = tx_ctrl.clear || (!tx_ctrl.push &&
                   (tx_stat.empty || (tx_ctrl.pop && tx_stat.level == 4'd1)));
    result.irq_out = enables_nxt[0] &&
                     ((ier_nxt[1] && tx_empty_nxt) || (ier_nxt[0] && !rx_empty_nxt));
  end

  // Touch the FIFOs only on the cycle the transaction actually retires.
  assign rx_ctrl_g = advance ? rx_ctrl : '0;
  assign tx_ctrl_g = advance ? tx_ctrl : '0;

  mur_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rx_ctrl_g),
    .push_data (s1_item_r.rx_byte),
    .head_data (rx_head),
    .stat      (rx_stat)
  );

  mur_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tx_ctrl_g),
    .push_data (lo),
    .head_data (tx_head),
    .stat      (tx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
      ier_r     <= '0;
      lcr_r     <= '0;
      mcr_r     <= '0;
      scratch_r <= '0;
      cntl_r    <= CNTL_RESET;
      baud_r    <= '0;
      overrun_r <= 1'b0;
    end else if (advance) begin
      enables_r <= enables_nxt;
      ier_r     <= ier_nxt;
      lcr_r     <= lcr_nxt;
      mcr_r     <= mcr_nxt;
      scratch_r <= scratch_nxt;
      cntl_r    <= cntl_nxt;
      baud_r    <= baud_nxt;
      overrun_r <= overrun_nxt;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

`ifndef SYNTHESIS
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input register overwritten while output stalled");
  a_tx_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.tx_valid) |-> (out_r.read_data == '0))
    else $error("tx byte result carries read data");
  a_irq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.irq_out) |-> enables_r[0])
    else $error("irq reported with uart disabled");
`endif

endmodule
